@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is held
`define GWSM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// clocked check, also live during reset
`define GWSM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define GWSM_ASSERT(lbl, prop, msg)
`define GWSM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/gwsm_pkg.sv @@
// types, constants and weight functions of the gaussian window sum
package gwsm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int VALUE_W    = 32;
    localparam int WGT_W      = 25;
    localparam int WGT_FRAC   = 24;
    localparam int ACC_W      = 58;
    localparam int EPS_W      = 16;
    localparam int DIM_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_RAD    = 7;

    localparam int DEF_MAX_WIDTH     = 2048;
    localparam int DEF_MAX_HEIGHT    = 2048;
    localparam int DEF_WINDOW_RADIUS = 3;
    localparam int DEF_GAUSS_SIGMA   = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_MODE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON      = 2'd3;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    localparam logic MODE_PRODUCT    = 1'b0;
    localparam logic MODE_RECIPROCAL = 1'b1;

    typedef struct packed {
        logic valid;
        logic clear;
        logic mode;
    } t_tap_req;

    typedef struct packed {
        logic idle;
    } t_tap_stat;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               saturated;
        logic               row_last;
        logic               frame_last;
    } t_result;

    // shift-subtract division, elaboration use only
    function automatic longint unsigned gwsm_udiv(input longint unsigned num,
                                                  input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // normalised q1.24 weight of one tap, raster index over the window
    function automatic logic [WGT_W-1:0] gwsm_weight(input int idx, input int rad,
                                                     input int sigma);
        longint unsigned sig2;
        longint unsigned u;
        longint unsigned term;
        longint unsigned base;
        longint unsigned total;
        longint unsigned raw_i;
        longint unsigned pw [0:2*MAX_RAD*MAX_RAD];
        int              i;
        sig2  = longint'(sigma) * longint'(sigma);
        u     = gwsm_udiv((64'd1 << 29) + (sig2 >> 1), sig2);
        term  = 64'd1 << 30;
        base  = 64'd1 << 30;
        for (int k = 1; k <= 10; k++) begin
            term = gwsm_udiv((term * u) >> 30, longint'(k));
            if (k % 2 == 1) base = base - term;
            else base = base + term;
        end
        pw[0] = 64'd1 << 30;
        for (int k = 1; k <= 2 * rad * rad; k++)
            pw[k] = (pw[k-1] * base + (64'd1 << 29)) >> 30;
        total = 0;
        raw_i = 0;
        i     = 0;
        for (int y = -rad; y <= rad; y++) begin
            for (int x = -rad; x <= rad; x++) begin
                if (i == idx) raw_i = pw[x*x + y*y];
                total = total + pw[x*x + y*y];
                i++;
            end
        end
        return WGT_W'(gwsm_udiv((raw_i << WGT_FRAC) + (total >> 1), total));
    endfunction

endpackage

@@ rtl/gwsm_ifs.sv @@
// valid/ready stream interfaces for pixels and results
interface gwsm_pix_if
    import gwsm_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output operation, output sample, input ready);
    modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface gwsm_res_if
    import gwsm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               saturated;
    logic               row_last;
    logic               frame_last;

    modport source (output valid, output value, output saturated, output row_last,
                    output frame_last, input ready);
    modport sink   (input valid, input value, input saturated, input row_last,
                    input frame_last, output ready);
endinterface

@@ rtl/gaussian_window_sum_mirror.sv @@
// top level: gaussian weighted window sum with mirrored borders
//
//  channel  | dir | signals                                     | transaction
//  i_pix    | in  | operation, sample                           | valid && ready
//  o_res    | out | value, saturated, row_last, frame_last      | valid && ready
//  i_cfg_*  | in  | we, idx, data                               | we high
//
// a pixel still inside the lead-in, or an ignored flush, is accepted without starting the tap phase
// sum mode 0: one line store read per tap
// sum mode 1: each tap waits for the 49-step divider
// reset is synchronous; the line store is not cleared and needs no sweep
// a result waiting in the output register does not stop the next pixel

`include "assert_macros.svh"

module gaussian_window_sum_mirror
    import gwsm_pkg::*;
#(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
    parameter int WINDOW_RADIUS = DEF_WINDOW_RADIUS,
    parameter int GAUSS_SIGMA   = DEF_GAUSS_SIGMA
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gwsm_pix_if.sink              i_pix,
    gwsm_res_if.source            o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int SIDE   = 2 * WINDOW_RADIUS + 1;
    localparam int TAPS   = SIDE * SIDE;
    localparam int NSLOT  = 2 * WINDOW_RADIUS + 2;
    localparam int SLOT_W = $clog2(NSLOT);
    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + WINDOW_RADIUS + 2);
    localparam int DEPTH  = NSLOT * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int TAP_W  = $clog2(TAPS + 1);
    localparam int TIDX_W = $clog2(TAPS);
    localparam int RY_W   = $clog2(WINDOW_RADIUS + 1) + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_TAPS  = 2'd1;
    localparam logic [1:0] ST_MAG   = 2'd2;
    localparam logic [1:0] ST_ROUND = 2'd3;

    localparam logic [ACC_W:0] HALF_PROD = (ACC_W+1)'(1) << 19;
    localparam logic [ACC_W:0] HALF_RECP = (ACC_W+1)'(1) << 15;

    logic [1:0]             r_state;
    logic [DIM_W-1:0]       r_img_w;
    logic [DIM_W-1:0]       r_img_h;
    logic                   r_mode;
    logic [EPS_W-1:0]       r_eps;
    logic [COL_W-1:0]       r_in_col;
    logic [ROW_W-1:0]       r_in_row;
    logic [SLOT_W-1:0]      r_in_slot;
    logic [COL_W-1:0]       r_out_col;
    logic [ROW_W-1:0]       r_out_row;
    logic [SLOT_W-1:0]      r_out_slot;
    logic signed [RY_W-1:0] r_ry;
    logic signed [RY_W-1:0] r_rx;
    logic [TAP_W-1:0]       r_tap;
    logic [TIDX_W-1:0]      r_d_tap;
    logic                   r_d_valid;
    logic [ACC_W-1:0]       r_mag;
    logic                   r_out_valid;
    t_result                r_out;

    logic [COL_W-1:0]        w_eff;
    logic [ROW_W-1:0]        h_eff;
    logic                    accept;
    logic                    in_frame;
    logic                    in_lead;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic                    issue;
    logic [ADDR_W-1:0]       rd_addr;
    logic [SLOT_W-1:0]       rd_slot;
    logic signed [ROW_W+1:0] ty;
    logic signed [ROW_W+1:0] last_r;
    logic signed [ROW_W+1:0] sdiff;
    logic signed [COL_W+1:0] tx;
    logic signed [COL_W+1:0] last_c;
    logic [SAMPLE_W-1:0]     rd_data;
    logic [WGT_W-1:0]        w_tab [TAPS];
    t_tap_req                tap_req;
    t_tap_stat               tap_stat;
    logic signed [ACC_W-1:0] tap_acc;
    logic                    taps_done;
    logic                    out_free;
    logic                    rlast;
    logic                    flast;
    logic [ACC_W:0]          rnd_sum;
    logic [ACC_W:0]          rnd_val;
    logic                    sat;

    for (genvar g = 0; g < TAPS; g++) begin : g_wtab
        localparam logic [WGT_W-1:0] WV = gwsm_weight(g, WINDOW_RADIUS, GAUSS_SIGMA);
        assign w_tab[g] = WV;
    end

    // frame size clamped to the supported range
    always_comb begin
        if (int'(r_img_w) < WINDOW_RADIUS + 1) w_eff = COL_W'(WINDOW_RADIUS + 1);
        else if (int'(r_img_w) > MAX_WIDTH) w_eff = COL_W'(MAX_WIDTH);
        else w_eff = COL_W'(r_img_w);
        if (int'(r_img_h) < WINDOW_RADIUS + 1) h_eff = ROW_W'(WINDOW_RADIUS + 1);
        else if (int'(r_img_h) > MAX_HEIGHT) h_eff = ROW_W'(MAX_HEIGHT);
        else h_eff = ROW_W'(r_img_h);
    end

    assign i_pix.ready = (r_state == ST_IDLE);
    assign accept      = i_pix.valid && i_pix.ready;
    assign in_frame    = r_in_row < h_eff;
    assign in_lead     = (r_in_row < ROW_W'(WINDOW_RADIUS)) ||
                         ((r_in_row == ROW_W'(WINDOW_RADIUS)) &&
                          (r_in_col < COL_W'(WINDOW_RADIUS)));
    assign wr_en       = accept && in_frame && (i_pix.operation == OP_SAMPLE);
    assign wr_addr     = ADDR_W'(r_in_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(r_in_col);

    // mirrored window position and its row slot
    always_comb begin
        last_r = $signed({2'b00, h_eff}) - (ROW_W+2)'(1);
        ty     = $signed({2'b00, r_out_row}) + (ROW_W+2)'(r_ry);
        if (ty < 0) ty = -ty;
        if (ty > last_r) ty = last_r + last_r - ty;
        if (ty < 0) ty = '0;
        if (ty > last_r) ty = last_r;
        sdiff = ty - $signed({2'b00, r_out_row}) + $signed((ROW_W+2)'(r_out_slot));
        if (sdiff < 0) sdiff = sdiff + (ROW_W+2)'(NSLOT);
        else if (sdiff >= (ROW_W+2)'(NSLOT)) sdiff = sdiff - (ROW_W+2)'(NSLOT);
        rd_slot = sdiff[SLOT_W-1:0];

        last_c = $signed({2'b00, w_eff}) - (COL_W+2)'(1);
        tx     = $signed({2'b00, r_out_col}) + (COL_W+2)'(r_rx);
        if (tx < 0) tx = -tx;
        if (tx > last_c) tx = last_c + last_c - tx;
        if (tx < 0) tx = '0;
        if (tx > last_c) tx = last_c;
        rd_addr = ADDR_W'(rd_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(tx[COL_W-1:0]);
    end

    assign issue = (r_state == ST_TAPS) && (r_tap != TAP_W'(TAPS)) &&
                   ((r_mode == MODE_PRODUCT) || (!r_d_valid && tap_stat.idle));
    assign taps_done = (r_tap == TAP_W'(TAPS)) && !r_d_valid && tap_stat.idle;

    gwsm_line_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_pix.sample),
        .i_re    (issue),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign tap_req.valid = r_d_valid;
    assign tap_req.clear = accept && !(in_frame && (i_pix.operation == OP_FLUSH)) && !in_lead;
    assign tap_req.mode  = r_mode;

    gwsm_tap_unit u_tap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (tap_req),
        .i_weight (w_tab[r_d_tap]),
        .i_sample ($signed(rd_data)),
        .i_eps    (r_eps),
        .o_stat   (tap_stat),
        .o_acc    (tap_acc)
    );

    assign out_free = !r_out_valid || o_res.ready;
    assign rlast    = r_out_col == (w_eff - 1'b1);
    assign flast    = rlast && (r_out_row == (h_eff - 1'b1));

    always_comb begin
        rnd_sum = {1'b0, r_mag} + ((r_mode == MODE_PRODUCT) ? HALF_PROD : HALF_RECP);
        rnd_val = (r_mode == MODE_PRODUCT) ? (rnd_sum >> 20) : (rnd_sum >> 16);
        sat     = |rnd_val[ACC_W:VALUE_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_img_w     <= DIM_W'(64);
            r_img_h     <= DIM_W'(64);
            r_mode      <= MODE_PRODUCT;
            r_eps       <= EPS_W'(7);
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_in_slot   <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_slot  <= '0;
            r_tap       <= '0;
            r_d_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_d_valid <= issue;
            if ((r_state == ST_ROUND) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT: begin
                        if (i_cfg_idx == CFG_IMAGE_WIDTH) r_img_w <= i_cfg_data[DIM_W-1:0];
                        else r_img_h <= i_cfg_data[DIM_W-1:0];
                        r_in_col   <= '0;
                        r_in_row   <= '0;
                        r_in_slot  <= '0;
                        r_out_col  <= '0;
                        r_out_row  <= '0;
                        r_out_slot <= '0;
                    end
                    CFG_SUM_MODE: r_mode <= i_cfg_data[0];
                    CFG_EPSILON:  r_eps  <= i_cfg_data[EPS_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept && !(in_frame && (i_pix.operation == OP_FLUSH))) begin
                        if (r_in_col == (w_eff - 1'b1)) begin
                            r_in_col  <= '0;
                            r_in_row  <= r_in_row + 1'b1;
                            r_in_slot <= (r_in_slot == SLOT_W'(NSLOT - 1)) ?
                                         '0 : r_in_slot + 1'b1;
                        end else begin
                            r_in_col <= r_in_col + 1'b1;
                        end
                        if (!in_lead) begin
                            r_state <= ST_TAPS;
                            r_tap   <= '0;
                            r_ry    <= RY_W'(-WINDOW_RADIUS);
                            r_rx    <= RY_W'(-WINDOW_RADIUS);
                        end
                    end
                end
                ST_TAPS: begin
                    if (issue) begin
                        r_tap <= r_tap + 1'b1;
                        if (r_rx == RY_W'(WINDOW_RADIUS)) begin
                            r_rx <= RY_W'(-WINDOW_RADIUS);
                            r_ry <= r_ry + 1'b1;
                        end else begin
                            r_rx <= r_rx + 1'b1;
                        end
                    end
                    if (taps_done) begin
                        r_state <= ST_MAG;
                    end
                end
                ST_MAG: begin
                    r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                        if (flast) begin
                            r_in_col   <= '0;
                            r_in_row   <= '0;
                            r_in_slot  <= '0;
                            r_out_col  <= '0;
                            r_out_row  <= '0;
                            r_out_slot <= '0;
                        end else if (rlast) begin
                            r_out_col  <= '0;
                            r_out_row  <= r_out_row + 1'b1;
                            r_out_slot <= (r_out_slot == SLOT_W'(NSLOT - 1)) ?
                                          '0 : r_out_slot + 1'b1;
                        end else begin
                            r_out_col <= r_out_col + 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_d_tap <= r_tap[TIDX_W-1:0];
        end
        if (r_state == ST_MAG) begin
            r_mag <= ((r_mode == MODE_PRODUCT) && tap_acc[ACC_W-1]) ?
                     ACC_W'(-tap_acc) : ACC_W'(tap_acc);
        end
        if ((r_state == ST_ROUND) && out_free) begin
            r_out.value      <= sat ? '1 : rnd_val[VALUE_W-1:0];
            r_out.saturated  <= sat;
            r_out.row_last   <= rlast;
            r_out.frame_last <= flast;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.value      = r_out.value;
    assign o_res.saturated  = r_out.saturated;
    assign o_res.row_last   = r_out.row_last;
    assign o_res.frame_last = r_out.frame_last;

    `GWSM_ASSERT(a_flast_has_rlast,
        r_out_valid && r_out.frame_last |-> r_out.row_last,
        "frame_last without row_last")
    `GWSM_ASSERT(a_frame_end_clears,
        (r_state == ST_ROUND) && out_free && flast |=> (r_out_row == '0) && (r_in_row == '0),
        "counters not cleared at frame end")
    `GWSM_ASSERT(a_unit_idle_outside,
        (r_state != ST_TAPS) |-> tap_stat.idle,
        "tap unit busy outside tap phase")
    `GWSM_ASSERT(a_in_ahead_of_out,
        (r_state == ST_IDLE) |-> (r_in_row >= r_out_row),
        "input row behind output row")
endmodule

@@ rtl/gwsm_line_store.sv @@
// row store memory, one write and one registered read port
module gwsm_line_store
    import gwsm_pkg::*;
#(
    parameter int DEPTH = 8 * DEF_MAX_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [SAMPLE_W-1:0]        i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [SAMPLE_W-1:0]        o_rdata
);
    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/gwsm_tap_unit.sv @@
// shared tap unit: multiplier, bit-serial divider and accumulator
module gwsm_tap_unit
    import gwsm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_tap_req                   i_req,
    input  logic [WGT_W-1:0]           i_weight,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [EPS_W-1:0]           i_eps,
    output t_tap_stat                  o_stat,
    output logic signed [ACC_W-1:0]    o_acc
);
    localparam int PROD_W = WGT_W + SAMPLE_W + 1;
    localparam int NUM_W  = WGT_W + WGT_FRAC;
    localparam int DEN_W  = SAMPLE_W + 4;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    logic                     r_prod_v;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_busy;
    logic                     r_q_v;
    logic [CNT_W-1:0]         r_cnt;
    logic [NUM_W-1:0]         r_num;
    logic [DEN_W-1:0]         r_rem;
    logic [DEN_W-1:0]         r_den;
    logic signed [ACC_W-1:0]  r_acc;

    logic [EPS_W-1:0] eps_eff;
    logic [DEN_W-1:0] den;
    logic [DEN_W:0]   rem_sh;
    logic             ge;

    always_comb begin
        eps_eff = (i_eps == '0) ? EPS_W'(1) : i_eps;
        // negative samples clamp to zero before the reciprocal
        if (!i_sample[SAMPLE_W-1] && i_sample != '0) begin
            den = DEN_W'({i_sample[SAMPLE_W-2:0], 4'b0000}) + DEN_W'(eps_eff);
        end else begin
            den = DEN_W'(eps_eff);
        end
        rem_sh = {r_rem, r_num[NUM_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
            r_busy   <= 1'b0;
            r_q_v    <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_prod_v <= i_req.valid && (i_req.mode == MODE_PRODUCT);
            r_q_v    <= 1'b0;
            if (i_req.valid && (i_req.mode == MODE_RECIPROCAL)) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_q_v  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_prod <= $signed({1'b0, i_weight}) * i_sample;
        end
        if (i_req.valid && (i_req.mode == MODE_RECIPROCAL)) begin
            r_num <= {i_weight, {WGT_FRAC{1'b0}}};
            r_rem <= '0;
            r_den <= den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], ge};
            r_rem <= ge ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.clear) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end else if (r_q_v) begin
            r_acc <= r_acc + $signed(ACC_W'(r_num));
        end
    end

    assign o_stat.idle = !r_prod_v && !r_busy && !r_q_v;
    assign o_acc       = r_acc;
endmodule
